@@ rtl/core/rsw_pkg.sv @@
// Package for the receive sequence window: status codes, window state type
// and sizing constants. No dependencies.
package rsw_pkg;

  // Width of a sequence number and of the stored history bitmap
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned HIST_W = 32;

  // Default window depth in sequences
  localparam int unsigned WINDOW_BITS_DEF = 32;

  // Serial arithmetic: a forward distance at or above this is not newer
  localparam logic [SEQ_W-1:0] HALF_SPACE = 32'h8000_0000;

  // Per-item result status
  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_TOO_OLD   = 2'd2,
    ST_INVALID   = 2'd3
  } rsw_status_t;

  // Window tracking state
  typedef struct packed {
    logic              seen_any;
    logic [SEQ_W-1:0]  newest;
    logic [HIST_W-1:0] history;
  } rsw_state_t;

endpackage

@@ rtl/core/rsw_update.sv @@
// Window update logic: judges one sequence number against the current window
// state and produces the next state and a status. Depends on rsw_pkg.
module rsw_update #(
  parameter int unsigned WINDOW_BITS = rsw_pkg::WINDOW_BITS_DEF
) (
  input  logic [rsw_pkg::SEQ_W-1:0] seq_i,
  input  rsw_pkg::rsw_state_t       state_i,
  output rsw_pkg::rsw_state_t       state_o,
  output rsw_pkg::rsw_status_t      status_o
);
  import rsw_pkg::*;

  // Effective window, clamped to the stored history width
  localparam int unsigned EFF_W = (WINDOW_BITS < 1) ? 1 :
                                  (WINDOW_BITS > HIST_W) ? HIST_W : WINDOW_BITS;
  localparam logic [63:0]       MASK64 = (64'd1 << EFF_W) - 64'd1;
  localparam logic [HIST_W-1:0] MASK   = MASK64[HIST_W-1:0];
  localparam logic [SEQ_W-1:0]  EFF_W_V = SEQ_W'(EFF_W);

  logic [SEQ_W-1:0]  fwd_dist;
  logic [SEQ_W-1:0]  back_dist;
  logic              is_newer;
  logic [5:0]        fwd_sh;
  logic [5:0]        back_sh;
  logic [HIST_W-1:0] slid_hist;
  logic [HIST_W-1:0] back_bit;

  assign fwd_dist  = seq_i - state_i.newest;
  assign back_dist = state_i.newest - seq_i;
  assign is_newer  = (fwd_dist != '0) && (fwd_dist < HALF_SPACE);
  // Distances used in shifts are at most the window, so six bits suffice
  assign fwd_sh    = fwd_dist[5:0];
  assign back_sh   = back_dist[5:0] - 6'd1;

  // Slide the history forward and mark the previous newest
  assign slid_hist = ((state_i.history << fwd_sh) | (HIST_W'(1) << (fwd_sh - 6'd1))) & MASK;
  assign back_bit  = HIST_W'(1) << back_sh;

  always_comb begin
    state_o  = state_i;
    status_o = ST_ACCEPTED;
    priority if (seq_i == '0) begin
      status_o = ST_INVALID;
    end else if (!state_i.seen_any) begin
      state_o.seen_any = 1'b1;
      state_o.newest   = seq_i;
      state_o.history  = '0;
    end else if (is_newer) begin
      state_o.newest  = seq_i;
      state_o.history = (fwd_dist > EFF_W_V) ? '0 : slid_hist;
    end else if (back_dist == '0) begin
      status_o = ST_DUPLICATE;
    end else if (back_dist > EFF_W_V) begin
      status_o = ST_TOO_OLD;
    end else if ((state_i.history & back_bit) != '0) begin
      status_o = ST_DUPLICATE;
    end else begin
      state_o.history = state_i.history | back_bit;
    end
  end

endmodule

@@ rtl/core/receive_sequence_window.sv @@
// Receive sequence window top level: input register, window state, update
// logic and result register. Depends on rsw_pkg and rsw_update.
// The input register loads on an accepted item; the result register loads
// from the update logic when it is empty or its result is taken. Throughput:
// one item per cycle unless the result side stalls; the state update in
// rsw_update is combinational. Reset (rst_n low, synchronous) clears both
// stage valids and the window state (no sequence seen, newest and bitmap zero).
module receive_sequence_window #(
  parameter int unsigned WINDOW_BITS = rsw_pkg::WINDOW_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seq_number
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] newest_seq, [63:32] window_bits
  output logic [1:0]  out_tuser   // [1:0] status
);
  import rsw_pkg::*;

  localparam int unsigned EFF_W = (WINDOW_BITS < 1) ? 1 :
                                  (WINDOW_BITS > HIST_W) ? HIST_W : WINDOW_BITS;
  localparam logic [63:0]       MASK64 = (64'd1 << EFF_W) - 64'd1;
  localparam logic [HIST_W-1:0] MASK   = MASK64[HIST_W-1:0];

  logic              s1_valid_r, s1_valid_nxt;
  logic [SEQ_W-1:0]  s1_seq_r;
  rsw_state_t        state_r, state_nxt;
  rsw_status_t       status_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsw_status_t       out_status_r;
  logic [SEQ_W-1:0]  out_newest_r;
  logic [HIST_W-1:0] out_window_r;
  logic              out_free;
  logic              s1_adv;
  logic              in_acc;

  // Handshake: result register frees when empty or taken
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  rsw_update #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_update (
    .seq_i   (s1_seq_r),
    .state_i (state_r),
    .state_o (state_nxt),
    .status_o(status_nxt)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload: capture input item, then the result of the update
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_seq_r <= in_tdata;
    end
    if (s1_adv) begin
      out_status_r <= status_nxt;
      out_newest_r <= state_nxt.newest;
      out_window_r <= state_nxt.history;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_window_r, out_newest_r};
  assign out_tuser  = out_status_r;

  // Before any valid sequence the newest and bitmap stay clear
  a_unseen_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.seen_any |-> (state_r.newest == '0 && state_r.history == '0))
    else $error("window state not clear before first sequence");

  // Once a sequence is seen, newest is never the reserved zero
  a_newest_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.seen_any |-> (state_r.newest != '0))
    else $error("newest sequence is zero after a valid sequence");

  // Bitmap never holds bits beyond the window depth
  a_hist_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.history & ~MASK) == '0)
    else $error("history bit set beyond window");

  // An invalid or rejected item leaves the window state alone
  a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (status_nxt == ST_INVALID || status_nxt == ST_TOO_OLD ||
                status_nxt == ST_DUPLICATE)) |=> $stable(state_r))
    else $error("window state changed on a rejected item");

  // Result register shows the state left by its item
  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_newest_r == state_r.newest && out_window_r == state_r.history))
    else $error("result does not match updated window state");

endmodule

@@ dv/receive_sequence_window_test.sv @@
// Testbench for receive_sequence_window: drives sequence numbers, predicts the
// window status, newest sequence and bitmap per item, and checks every result.
// Depends on rsw_pkg and the receive_sequence_window RTL.
module receive_sequence_window_test;
  import rsw_pkg::*;

  localparam int unsigned WIN_DEPTH = WINDOW_BITS_DEF;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_LINES = 60;

  typedef struct packed {
    rsw_status_t       status;
    logic [SEQ_W-1:0]  newest;
    logic [HIST_W-1:0] bitmap;
  } window_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  receive_sequence_window #(.WINDOW_BITS(WIN_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Sequences waiting to be offered and window results waiting to arrive
  logic [SEQ_W-1:0] seq_pending_q[$];
  window_result_t   window_expect_q[$];

  // Predicted window state
  logic              pred_started = 1'b0;
  logic [SEQ_W-1:0]  pred_newest = '0;
  logic [HIST_W-1:0] pred_bitmap = '0;

  // Stimulus-side view of the newest sequence, used to aim items at the window
  logic              gen_started = 1'b0;
  logic [SEQ_W-1:0]  gen_newest = '0;

  int unsigned mismatches = 0;
  int unsigned seq_accepted = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        in_fire = 1'b0;
  logic        quiet = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the predicted window by one received sequence
  function automatic window_result_t track_sequence(logic [SEQ_W-1:0] seq);
    window_result_t res;
    logic [SEQ_W-1:0] offset;
    logic [63:0] shifted;
    logic [63:0] mask;
    int unsigned w;
    w = WIN_DEPTH;
    if (w < 1) w = 1;
    if (w > HIST_W) w = HIST_W;
    mask = (64'd1 << w) - 64'd1;
    res.status = ST_ACCEPTED;
    if (seq == '0) begin
      res.status = ST_INVALID;
    end else if (!pred_started) begin
      pred_started = 1'b1;
      pred_newest = seq;
      pred_bitmap = '0;
    end else begin
      offset = seq - pred_newest;
      if (offset != '0 && offset < HALF_SPACE) begin
        // Slide the window forward and mark the old newest
        if (offset > w) begin
          pred_bitmap = '0;
        end else begin
          shifted = ({32'd0, pred_bitmap} << offset) | (64'd1 << (offset - 1));
          pred_bitmap = shifted[HIST_W-1:0] & mask[HIST_W-1:0];
        end
        pred_newest = seq;
      end else begin
        offset = pred_newest - seq;
        if (offset == '0) res.status = ST_DUPLICATE;
        else if (offset > w) res.status = ST_TOO_OLD;
        else if (pred_bitmap[offset-1]) res.status = ST_DUPLICATE;
        else pred_bitmap[offset-1] = 1'b1;
      end
    end
    res.newest = pred_newest;
    res.bitmap = pred_bitmap;
    return res;
  endfunction

  // Queue one sequence and follow the newest one on the stimulus side
  task automatic queue_sequence(input logic [SEQ_W-1:0] seq);
    logic [SEQ_W-1:0] offset;
    offset = seq - gen_newest;
    if (seq != '0) begin
      if (!gen_started) begin
        gen_started = 1'b1;
        gen_newest = seq;
      end else if (offset != '0 && offset < HALF_SPACE) begin
        gen_newest = seq;
      end
    end
    seq_pending_q.insert(seq_pending_q.size(), seq);
  endtask

  // Pick a sequence that lands mostly around the current window
  function automatic logic [SEQ_W-1:0] pick_sequence();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return gen_newest + $urandom_range(1, 4);
    if (r < 57) return gen_newest - $urandom_range(1, WIN_DEPTH + 2);
    if (r < 63) return gen_newest;
    if (r < 69) return gen_newest + $urandom_range(WIN_DEPTH, WIN_DEPTH + 40);
    if (r < 73) return gen_newest + ($urandom & 32'h7FFF_FFFF) + 1;
    if (r < 78) return '0;
    if (r < 83) return gen_newest + HALF_SPACE;
    if (r < 89) return gen_newest - $urandom_range(WIN_DEPTH + 1, 32'h0001_0000);
    return $urandom;
  endfunction

  // Mostly short gaps, a few long ones, none in quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_LINES)
      $display("mismatch on %s at %0t: got %h, expected %h", field, $time, got, want);
    mismatches++;
  endtask

  // Record accepted items and predict their results
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready && rst_n;
    if (rst_n && in_tvalid && in_tready) begin
      window_expect_q.insert(window_expect_q.size(), track_sequence(in_tdata));
      seq_accepted <= seq_accepted + 1;
    end
  end

  // Offer pending sequences, hold each until accepted, then idle a while
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (seq_pending_q.size() != 0) begin
        in_tdata <= seq_pending_q.pop_front();
        in_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once the random part is under way
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && seq_accepted >= 60) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Drive the result-side ready with random stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (hold_left != 0 || !rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    window_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (window_expect_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[31:0], '0);
      end else begin
        want = window_expect_q.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", {30'd0, out_tuser}, {30'd0, want.status});
        if (out_tdata[31:0] !== want.newest)
          report_mismatch("newest_seq", out_tdata[31:0], want.newest);
        if (out_tdata[63:32] !== want.bitmap)
          report_mismatch("window_bits", out_tdata[63:32], want.bitmap);
      end
    end
  end

  // Directed items, then random chunks, then drain and decide
  initial begin
    logic [SEQ_W-1:0] directed[$];
    directed = '{
      32'h0000_0000,  // zero before any sequence
      32'hFFFF_FFF0,  // first valid sequence
      32'hFFFF_FFF0,  // same as newest
      32'hFFFF_FFF2,
      32'hFFFF_FFF1,  // older, inside window, unmarked
      32'hFFFF_FFF1,  // older, already marked
      32'hFFFF_FFFF,
      32'h0000_0001,  // wrap forward past zero
      32'h0000_0000,  // zero with state present
      32'hFFFF_FFE1,  // back by exactly the window
      32'hFFFF_FFE0,  // back by one more than the window
      32'h8000_0001,  // exactly half the space away
      32'h0000_0021,  // forward by exactly the window
      32'h0000_0042,  // forward by more than the window
      32'h8000_0041,  // largest forward step
      32'h8000_0040,
      32'h0000_0042,  // far behind now
      32'h5555_5555,
      32'hAAAA_AAAA,
      32'hAAAA_AAAB,
      32'hFFFF_FFFF,
      32'h7FFF_FFFF
    };
    foreach (directed[i]) queue_sequence(directed[i]);
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    while (seq_pending_q.size() != 0) @(posedge clk);

    for (int chunk = 0; chunk < 6; chunk++) begin
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 100; n++) queue_sequence(pick_sequence());
      while (seq_pending_q.size() != 0) @(posedge clk);
    end
    quiet = 1'b0;

    while (seq_pending_q.size() != 0 || in_tvalid) @(posedge clk);
    while (window_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
